// ===== design/sparse_polynomial_sum_unit_macros.svh =====
// Assertion helpers for the RTL file that carries checks.
// Each expects signals named clk and arst_n in the enclosing module.
`ifndef SPARSE_POLYNOMIAL_SUM_UNIT_MACROS_SVH
`define SPARSE_POLYNOMIAL_SUM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPS_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SPS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

// ===== design/sps_pkg.sv =====
package sps_pkg;

	localparam int COEF_IN_W  = 32;
	localparam int COEF_SUM_W = 36;
	localparam int POWER_W    = 16;

	// One stored term
	typedef struct packed {
		logic signed [POWER_W-1:0]    power;
		logic signed [COEF_SUM_W-1:0] coef;
	} sps_entry_t;

	// Saturating add of an input coefficient onto a stored sum
	function automatic logic signed [COEF_SUM_W-1:0] sat_add(
		input logic signed [COEF_SUM_W-1:0] a,
		input logic signed [COEF_IN_W-1:0]  b
	);
		logic signed [COEF_SUM_W:0] sum;
		sum = {a[COEF_SUM_W-1], a} + {{(COEF_SUM_W - COEF_IN_W + 1){b[COEF_IN_W-1]}}, b};
		if (sum[COEF_SUM_W] != sum[COEF_SUM_W-1]) begin
			if (sum[COEF_SUM_W]) begin
				sat_add = {1'b1, {(COEF_SUM_W-1){1'b0}}};
			end else begin
				sat_add = {1'b0, {(COEF_SUM_W-1){1'b1}}};
			end
		end else begin
			sat_add = sum[COEF_SUM_W-1:0];
		end
	endfunction

endpackage

// ===== design/sps_store.sv =====
// Term store: one write port, one registered read port
module sps_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  sps_pkg::sps_entry_t   wr_entry,
	input  logic [AW-1:0]         rd_addr,
	output sps_pkg::sps_entry_t   rd_q
);

	sps_pkg::sps_entry_t mem [DEPTH];

	// write and read, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

endmodule

// ===== design/sparse_polynomial_sum_unit.sv =====
// Sparse polynomial sum: terms fold into a power-sorted store, emitted on set end.
// Per term: a linear search of the store, then for a new power an insert by the
// one-entry-per-cycle shift through the single read port of the store.
// Emission: a scan over the stored entries, held up by output stalls, starts
// once the set-end term has been folded.
// Reset clears entry count, drop flag and control; store contents are left as is.
module sparse_polynomial_sum_unit #(
	parameter int MAX_TERMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // coefficient[31:0], power[47:32]
	input  logic        s_tlast,   // set_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // sum_coefficient[35:0], sum_power[51:36], zero pad
	output logic        m_tlast,   // last
	output logic [1:0]  m_tuser    // empty_res[0], overflow[1]
);

	localparam int AW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SRCH   = 3'd1;
	localparam logic [2:0] ST_INS    = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_PUT    = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;
	localparam logic [2:0] ST_EM_CHK = 3'd6;
	localparam logic [2:0] ST_EM_END = 3'd7;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [CW-1:0] count_q, count_d;
	logic          ovf_q, ovf_d;
	logic          pend_q, pend_d;
	sps_pkg::sps_entry_t pend_entry_q, pend_entry_d;

	logic signed [sps_pkg::COEF_IN_W-1:0] coef_q;
	logic signed [sps_pkg::POWER_W-1:0]   pow_q;
	logic                                 end_q;

	logic                                  m_tvalid_q;
	logic signed [sps_pkg::COEF_SUM_W-1:0] out_coef_q;
	logic signed [sps_pkg::POWER_W-1:0]    out_pow_q;
	logic                                  out_last_q;
	logic                                  out_empty_q;
	logic                                  out_ovf_q;

	logic                  load_out;
	sps_pkg::sps_entry_t   ld_entry;
	logic                  ld_last;
	logic                  ld_empty;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	sps_pkg::sps_entry_t   wr_entry;
	logic [AW-1:0]         rd_addr;
	sps_pkg::sps_entry_t   rd_q;

	logic [CW-1:0] idx_p1, idx_m1, idx_m2, count_m1;
	logic          accept;
	logic          out_free;
	logic          hit, above, nz;

	sps_store #(
		.DEPTH (MAX_TERMS),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.rd_q     (rd_q)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign idx_p1   = idx_q + 1'b1;
	assign idx_m1   = idx_q - 1'b1;
	assign idx_m2   = idx_q - 2'd2;
	assign count_m1 = count_q - 1'b1;

	assign hit   = (rd_q.power == pow_q);
	assign above = ($signed(rd_q.power) > pow_q);
	assign nz    = (rd_q.coef != '0);

	// sequencer: search, insert by shifting, then emission scan
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		count_d      = count_q;
		ovf_d        = ovf_q;
		pend_d       = pend_q;
		pend_entry_d = pend_entry_q;
		load_out     = 1'b0;
		ld_entry     = pend_entry_q;
		ld_last      = 1'b0;
		ld_empty     = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = idx_q[AW-1:0];
		wr_entry     = rd_q;
		rd_addr      = idx_q[AW-1:0];

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (count_q == '0) begin
						pos_d   = '0;
						state_d = ST_INS;
					end else begin
						idx_d   = '0;
						rd_addr = '0;
						state_d = ST_SRCH;
					end
				end
			end
			// rd_q holds entry idx_q
			ST_SRCH: begin
				if (hit) begin
					wr_en         = 1'b1;
					wr_entry.coef = sps_pkg::sat_add(rd_q.coef, coef_q);
					state_d       = ST_FIN;
				end else if (above) begin
					pos_d   = idx_q;
					state_d = ST_INS;
				end else if (idx_p1 == count_q) begin
					pos_d   = count_q;
					state_d = ST_INS;
				end else begin
					idx_d   = idx_p1;
					rd_addr = idx_p1[AW-1:0];
				end
			end
			// new power: ignore zero, drop when full, else make room
			ST_INS: begin
				if (coef_q == '0) begin
					state_d = ST_FIN;
				end else if (count_q == CW'(MAX_TERMS)) begin
					ovf_d   = 1'b1;
					state_d = ST_FIN;
				end else if (pos_q == count_q) begin
					state_d = ST_PUT;
				end else begin
					idx_d   = count_q;
					rd_addr = count_m1[AW-1:0];
					state_d = ST_SHIFT;
				end
			end
			// rd_q holds entry idx_q-1, moved up to idx_q
			ST_SHIFT: begin
				wr_en    = 1'b1;
				wr_addr  = idx_q[AW-1:0];
				wr_entry = rd_q;
				if (idx_m1 == pos_q) begin
					state_d = ST_PUT;
				end else begin
					idx_d   = idx_m1;
					rd_addr = idx_m2[AW-1:0];
				end
			end
			ST_PUT: begin
				wr_en         = 1'b1;
				wr_addr       = pos_q[AW-1:0];
				wr_entry.power = pow_q;
				wr_entry.coef  = {{(sps_pkg::COEF_SUM_W - sps_pkg::COEF_IN_W){coef_q[31]}},
				                  coef_q};
				count_d       = count_q + 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				if (!end_q) begin
					state_d = ST_IDLE;
				end else if (count_q == '0) begin
					state_d = ST_EM_END;
				end else begin
					idx_d   = '0;
					rd_addr = '0;
					state_d = ST_EM_CHK;
				end
			end
			// one entry held back so the final result can carry last
			ST_EM_CHK: begin
				if (!(nz && pend_q && !out_free)) begin
					if (nz && pend_q) begin
						load_out = 1'b1;
					end
					if (nz) begin
						pend_d       = 1'b1;
						pend_entry_d = rd_q;
					end
					if (idx_p1 == count_q) begin
						state_d = ST_EM_END;
					end else begin
						idx_d   = idx_p1;
						rd_addr = idx_p1[AW-1:0];
					end
				end
			end
			ST_EM_END: begin
				if (out_free) begin
					load_out = 1'b1;
					ld_last  = 1'b1;
					if (!pend_q) begin
						ld_empty = 1'b1;
						ld_entry = '0;
					end
					count_d = '0;
					ovf_d   = 1'b0;
					pend_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			pos_q      <= '0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			pend_q  <= pend_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_entry_q <= pend_entry_d;
		if (accept) begin
			coef_q <= s_tdata[31:0];
			pow_q  <= s_tdata[47:32];
			end_q  <= s_tlast;
		end
		if (load_out) begin
			out_coef_q  <= ld_entry.coef;
			out_pow_q   <= ld_entry.power;
			out_last_q  <= ld_last;
			out_empty_q <= ld_empty;
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_pow_q, out_coef_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ovf_q, out_empty_q};

`include "sparse_polynomial_sum_unit_macros.svh"

	`SPS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(MAX_TERMS))
	`SPS_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q != ST_IDLE)
	`SPS_ASSERT_IMPL(a_shift_range, state_q == ST_SHIFT, idx_q > pos_q && idx_q <= count_q)
	`SPS_ASSERT_IMPL(a_empty_last, m_tvalid_q && out_empty_q, out_last_q && out_coef_q == '0)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CAPACITY = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint SUM_MAX = 64'sd34359738367;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	// One input term as queued for the driver
	typedef struct {
		logic [sps_pkg::COEF_IN_W-1:0] coef;
		logic [sps_pkg::POWER_W-1:0]   pw;
		bit                            set_end;
		bit                            drain_first;
	} poly_term_t;

	// One expected term of the emitted sum
	typedef struct {
		logic signed [sps_pkg::COEF_SUM_W-1:0] coef;
		logic signed [sps_pkg::POWER_W-1:0]    pw;
		bit                                    last;
		bit                                    empty;
		bit                                    ovf;
	} sum_term_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;    // coefficient[31:0], power[47:32]
	logic        s_tlast = 1'b0;  // set_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;         // sum_coefficient[35:0], sum_power[51:36], zero pad
	logic        m_tlast;         // last
	logic [1:0]  m_tuser;         // empty_res[0], overflow[1]

	poly_term_t pending_terms[$];
	sum_term_t  expected_sums[$];
	sum_term_t  want;

	// Predictor state: power-sorted store of summed terms
	logic signed [sps_pkg::POWER_W-1:0]    power_slot[CAPACITY];
	logic signed [sps_pkg::COEF_SUM_W-1:0] coef_slot[CAPACITY];
	int slots_used = 0;
	bit terms_dropped = 1'b0;

	int terms_queued = 0;
	int terms_accepted = 0;
	int mismatches = 0;
	int cycle_count = 0;
	bit in_fire = 1'b0;
	int in_gap = 0;
	int in_calm = 0;
	int out_stall = 0;
	int out_calm = 0;

	sparse_polynomial_sum_unit #(.MAX_TERMS(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// Mostly short idle gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// Fold one term into the sorted store: add onto a matching power, else insert
	function automatic void merge_term(logic signed [sps_pkg::COEF_IN_W-1:0] c,
			logic signed [sps_pkg::POWER_W-1:0] p);
		int pos;
		longint s;
		pos = 0;
		while (pos < slots_used && power_slot[pos] < p) pos++;
		if (pos < slots_used && power_slot[pos] == p) begin
			s = longint'(coef_slot[pos]) + longint'(c);
			if (s > SUM_MAX) s = SUM_MAX;
			if (s < SUM_MIN) s = SUM_MIN;
			coef_slot[pos] = s[sps_pkg::COEF_SUM_W-1:0];
			return;
		end
		if (c == 0) return;
		if (slots_used >= CAPACITY) begin
			terms_dropped = 1'b1;
			return;
		end
		for (int k = slots_used; k > pos; k--) begin
			power_slot[k] = power_slot[k-1];
			coef_slot[k] = coef_slot[k-1];
		end
		power_slot[pos] = p;
		coef_slot[pos] = c;
		slots_used++;
	endfunction

	// Set end: queue the nonzero sums in ascending power, or one empty marker
	function automatic void emit_sum();
		sum_term_t t;
		int first_idx;
		first_idx = expected_sums.size();
		for (int k = 0; k < slots_used; k++) begin
			if (coef_slot[k] != 0) begin
				t.coef = coef_slot[k];
				t.pw = power_slot[k];
				t.last = 1'b0;
				t.empty = 1'b0;
				t.ovf = terms_dropped;
				expected_sums.push_back(t);
			end
		end
		if (expected_sums.size() > first_idx) begin
			expected_sums[expected_sums.size()-1].last = 1'b1;
		end else begin
			t.coef = '0;
			t.pw = '0;
			t.last = 1'b1;
			t.empty = 1'b1;
			t.ovf = terms_dropped;
			expected_sums.push_back(t);
		end
		slots_used = 0;
		terms_dropped = 1'b0;
	endfunction

	task automatic check_field(string field, longint exp_val, longint act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
			mismatches++;
		end
	endtask

	task automatic add_term(logic [sps_pkg::COEF_IN_W-1:0] c,
			logic [sps_pkg::POWER_W-1:0] pw, bit set_end, bit drain_first = 1'b0);
		poly_term_t t;
		t.coef = c;
		t.pw = pw;
		t.set_end = set_end;
		t.drain_first = drain_first;
		pending_terms.push_back(t);
		terms_queued++;
	endtask

	// Short set with random content; narrow powers collide, some terms cancel
	task automatic make_mixed_set(bit wide_powers, bit drain_first);
		int len;
		int r;
		int j;
		logic [sps_pkg::COEF_IN_W-1:0] c;
		logic [sps_pkg::POWER_W-1:0] pw_v;
		logic [sps_pkg::COEF_IN_W-1:0] seen_c[$];
		logic [sps_pkg::POWER_W-1:0] seen_p[$];
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			if (wide_powers) pw_v = 16'($urandom_range(0, 65535));
			else pw_v = 16'($urandom_range(0, 8) - 4);
			r = $urandom_range(0, 99);
			if (r < 8) begin
				c = 32'h7FFF_FFFF;
			end else if (r < 16) begin
				c = 32'h8000_0000;
			end else if (r < 28) begin
				c = '0;
			end else if (r < 48 && seen_c.size() > 0) begin
				j = $urandom_range(0, seen_c.size() - 1);
				c = -seen_c[j];
				pw_v = seen_p[j];
			end else if (r < 70) begin
				c = $urandom_range(0, 20) - 10;
			end else begin
				c = $urandom();
			end
			seen_c.push_back(c);
			seen_p.push_back(pw_v);
			add_term(c, pw_v, i == len - 1, drain_first && i == 0);
		end
	endtask

	// More distinct powers than the store holds, in shuffled order
	task automatic make_overflow_set();
		logic [sps_pkg::POWER_W-1:0] pw_list[70];
		logic [sps_pkg::POWER_W-1:0] tmp;
		logic [sps_pkg::COEF_IN_W-1:0] first_coef;
		int j;
		for (int i = 0; i < 70; i++) pw_list[i] = 16'(-2000 + 50 * i);
		for (int i = 69; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = pw_list[i];
			pw_list[i] = pw_list[j];
			pw_list[j] = tmp;
		end
		first_coef = $urandom() | 32'd1;
		add_term(first_coef, pw_list[0], 1'b0, 1'b1);
		for (int i = 1; i < 70; i++) add_term($urandom() | 32'd1, pw_list[i], 1'b0);
		// stored powers still accumulate once the store is full
		add_term(-first_coef, pw_list[0], 1'b0);
		add_term('0, 16'h7000, 1'b0);
		add_term($urandom() | 32'd1, pw_list[1], 1'b1);
	endtask

	// Drive one power past the positive limit and another past the negative one
	task automatic make_saturation_set();
		for (int i = 0; i < 17; i++) begin
			add_term(32'h7FFF_FFFF, 16'd5, 1'b0, i == 0);
			add_term(32'h8000_0000, -16'sd5, 1'b0);
		end
		add_term(32'hFFFF_FFFF, 16'd5, 1'b1);
	endtask

	// Input driver: next term once the previous transaction completed
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_terms.size() != 0 &&
					!(pending_terms[0].drain_first && expected_sums.size() != 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {pending_terms[0].pw, pending_terms[0].coef};
				s_tlast <= pending_terms[0].set_end;
				void'(pending_terms.pop_front());
				if (in_calm > 0) begin
					in_gap <= 0;
					in_calm <= in_calm - 1;
				end else begin
					in_gap <= pick_gap();
					if ($urandom_range(0, 29) == 0) in_calm <= $urandom_range(10, 30);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output backpressure with random stalls and stall-free stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_stall > 0) begin
				m_tready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				m_tready <= 1'b1;
				if (out_calm > 0) begin
					out_calm <= out_calm - 1;
				end else if ($urandom_range(0, 3) == 0) begin
					out_stall <= pick_gap();
				end else if ($urandom_range(0, 39) == 0) begin
					out_calm <= $urandom_range(20, 60);
				end
			end
		end
	end

	// Monitor: predict on each input transaction, check each output transaction
	always @(posedge clk) begin
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			merge_term(s_tdata[31:0], s_tdata[47:32]);
			if (s_tlast) emit_sum();
			terms_accepted++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_sums.size() == 0) begin
				$error("unexpected result: sum_coefficient %0d, sum_power %0d",
					$signed(m_tdata[35:0]), $signed(m_tdata[51:36]));
				mismatches++;
			end else begin
				want = expected_sums.pop_front();
				check_field("sum_coefficient", want.coef, $signed(m_tdata[35:0]));
				check_field("sum_power", want.pw, $signed(m_tdata[51:36]));
				check_field("last", want.last, m_tlast);
				check_field("empty_res", want.empty, m_tuser[0]);
				check_field("overflow", want.ovf, m_tuser[1]);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		// directed: field extremes
		add_term(32'h7FFF_FFFF, 16'h7FFF, 1'b1);
		add_term(32'h8000_0000, 16'h8000, 1'b1);
		// full cancellation gives the empty marker
		add_term(32'd5, 16'd3, 1'b0);
		add_term(-32'sd5, 16'd3, 1'b1);
		// lone zero term with a new power
		add_term('0, 16'd7, 1'b1);
		// zero-sum slots, revival of a cancelled power, ignored zero term
		add_term(32'd4, 16'd2, 1'b0);
		add_term(-32'sd4, 16'd2, 1'b0);
		add_term(32'd1, -16'sd1, 1'b0);
		add_term(32'd3, 16'd10, 1'b0);
		add_term(-32'sd3, 16'd10, 1'b0);
		add_term(32'd9, 16'd2, 1'b0);
		add_term('0, 16'd5, 1'b0);
		add_term(-32'sd7, 16'h8000, 1'b0);
		add_term(32'd6, 16'h7FFF, 1'b1);
		// alternating bit patterns
		add_term(32'h5555_5555, 16'h5555, 1'b0);
		add_term(32'hAAAA_AAAA, 16'hAAAA, 1'b1);
		// sum beyond 32 bits without saturation
		add_term(32'h8000_0000, 16'd0, 1'b0);
		add_term(32'h8000_0000, 16'd0, 1'b1);

		// random sets, with one capacity overrun and one saturation set
		make_mixed_set(1'b0, 1'b1);
		while (terms_queued < 205) begin
			if (terms_queued > 50 && terms_queued < 60) make_overflow_set();
			else if (terms_queued > 130 && terms_queued < 140) make_saturation_set();
			else make_mixed_set($urandom_range(0, 2) == 0, $urandom_range(0, 9) == 0);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (terms_accepted < terms_queued || expected_sums.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
